>>> rtl/core/vpw_pkg.sv
// Shared types, constants and saturation helpers for the vertex project-to-window unit.
// No dependencies; vpw_mac, vpw_div and the top unit refer to this package by scoped names.
package vpw_pkg;

   // Matrix store geometry.
   localparam int MATRIX_WORDS = 32;
   localparam int ADDR_W       = $clog2(MATRIX_WORDS);
   localparam int WORD_W       = 48;

   // Datapath widths.
   localparam int COORD_W = 32;
   localparam int HALF_W  = 25;
   localparam int PROD_W  = COORD_W + HALF_W;
   localparam int ACC_W   = 84;
   localparam int CLIP_W  = 64;
   localparam int QUOT_W  = 42;
   localparam int VPM_W   = QUOT_W + 16;
   localparam int WIN_W   = 60;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_VP_LEFT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_BOTTOM   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_VIEW = 3'd4;

   // Operation codes of an input word.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_PROJECT = 1'b1;

   // Input word.
   typedef struct packed {
      logic                      op;
      logic [ADDR_W-1:0]         word_index;
      logic signed [WORD_W-1:0]  word_value;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   // Result word.
   typedef struct packed {
      logic signed [COORD_W-1:0] win_x;
      logic signed [COORD_W-1:0] win_y;
      logic signed [COORD_W-1:0] win_depth;
      logic signed [COORD_W-1:0] eye_x;
      logic signed [COORD_W-1:0] eye_y;
      logic signed [COORD_W-1:0] eye_z;
      logic                      in_front;
      logic                      w_zero;
   } rsp_type;

   // Control of one multiply-accumulate step.
   typedef struct packed {
      logic en;
      logic hi;
      logic first;
   } mac_ctl_type;

   // Position of a step in the product schedule.
   typedef struct packed {
      logic       valid;
      logic       phase;
      logic [1:0] row;
      logic [1:0] term;
      logic       hi;
   } tag_type;

   // Saturate a 60 bit signed value to 32 bits.
   function automatic logic [COORD_W-1:0] sat32(input logic [WIN_W-1:0] v);
      logic same;
      same = (v[WIN_W-1:COORD_W-1] == '0) || (v[WIN_W-1:COORD_W-1] == '1);
      if (same) begin
         sat32 = v[COORD_W-1:0];
      end else if (v[WIN_W-1]) begin
         sat32 = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat32 = {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   // Saturate a 68 bit signed value to 64 bits.
   function automatic logic [CLIP_W-1:0] sat64(input logic [ACC_W-17:0] v);
      logic same;
      same = (v[ACC_W-17:CLIP_W-1] == '0) || (v[ACC_W-17:CLIP_W-1] == '1);
      if (same) begin
         sat64 = v[CLIP_W-1:0];
      end else if (v[ACC_W-17]) begin
         sat64 = {1'b1, {(CLIP_W-1){1'b0}}};
      end else begin
         sat64 = {1'b0, {(CLIP_W-1){1'b1}}};
      end
   endfunction

endpackage

>>> rtl/core/vpw_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module vpw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> rtl/core/vpw_mac.sv
// Shared multiply-accumulate unit: one 32 x 25 signed product per cycle into an 84 bit sum.
// Depends on vpw_pkg.
module vpw_mac (
   input  logic                                    clock,
   input  logic                                    reset,
   input  vpw_pkg::mac_ctl_type                    ctl,
   input  logic signed [vpw_pkg::COORD_W-1:0]      a,
   input  logic [vpw_pkg::WORD_W-1:0]              d,
   output logic signed [vpw_pkg::ACC_W-1:0]        acc
);

   logic signed [vpw_pkg::HALF_W-1:0] b;
   logic signed [vpw_pkg::PROD_W-1:0] p;
   logic [vpw_pkg::ACC_W-1:0]         p_ext;
   logic [vpw_pkg::ACC_W-1:0]         prod_ff;
   logic [vpw_pkg::ACC_W-1:0]         prod_in;
   logic [vpw_pkg::ACC_W-1:0]         acc_ff;
   logic                              en2_ff;
   logic                              first2_ff;

   // The 48 bit word is taken in two halves: the low half unsigned, the high half signed.
   always_comb begin
      if (ctl.hi) begin
         b = {d[vpw_pkg::WORD_W-1], d[vpw_pkg::WORD_W-1:24]};
      end else begin
         b = {1'b0, d[23:0]};
      end
      p     = a * b;
      p_ext = {{(vpw_pkg::ACC_W-vpw_pkg::PROD_W){p[vpw_pkg::PROD_W-1]}}, p};
      if (ctl.hi) begin
         prod_in = p_ext << 24;
      end else begin
         prod_in = p_ext;
      end
   end

   // Product register, then the accumulator.
   always_ff @(posedge clock) begin
      if (reset) begin
         en2_ff    <= 1'b0;
         first2_ff <= 1'b0;
      end else begin
         en2_ff    <= ctl.en;
         first2_ff <= ctl.first;
      end
      prod_ff <= prod_in;
      if (en2_ff) begin
         acc_ff <= (first2_ff ? '0 : acc_ff) + prod_ff;
      end
   end

   assign acc = acc_ff;

endmodule

>>> rtl/core/vpw_div.sv
// Restoring divider for the perspective divide: (c * 2^30) / w, truncated, clamped to +-2^40.
// Depends on vpw_pkg. One quotient bit per cycle, 42 bits a divide.
module vpw_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [vpw_pkg::CLIP_W-1:0]    num,
   input  logic signed [vpw_pkg::CLIP_W-1:0]    den,
   output logic                                 done,
   output logic signed [vpw_pkg::QUOT_W-1:0]    quot
);

   localparam logic [vpw_pkg::QUOT_W-1:0] LIMIT = 42'd1 << 40;

   logic [vpw_pkg::CLIP_W-1:0]  uc;
   logic [vpw_pkg::CLIP_W-1:0]  ud;
   logic [vpw_pkg::CLIP_W-1:0]  r_ff;
   logic [vpw_pkg::CLIP_W-1:0]  d_ff;
   logic [vpw_pkg::QUOT_W-1:0]  nb_ff;
   logic [vpw_pkg::QUOT_W-1:0]  q_ff;
   logic [5:0]                  cnt_ff;
   logic                        run_ff;
   logic                        ovf_ff;
   logic                        neg_ff;
   logic                        done_ff;
   logic [vpw_pkg::QUOT_W-1:0]  quot_ff;
   logic [vpw_pkg::CLIP_W:0]    t;
   logic [vpw_pkg::CLIP_W:0]    t_sub;
   logic                        ge;
   logic [vpw_pkg::QUOT_W-1:0]  q_mag;

   // Magnitudes of the operands, one trial subtraction and the clamp of the quotient magnitude.
   always_comb begin
      uc    = num[vpw_pkg::CLIP_W-1] ? -num : num;
      ud    = den[vpw_pkg::CLIP_W-1] ? -den : den;
      t     = {r_ff, nb_ff[vpw_pkg::QUOT_W-1]};
      t_sub = t - {1'b0, d_ff};
      ge    = (t >= {1'b0, d_ff});
      if (ovf_ff || (q_ff > LIMIT)) begin
         q_mag = LIMIT;
      end else begin
         q_mag = q_ff;
      end
   end

   // Sequencer: set up on start, then one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'(vpw_pkg::QUOT_W);
         end else if (run_ff) begin
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
      if (start) begin
         // Quotients of 2^42 or more are caught here and clamped at the end.
         r_ff   <= {12'd0, uc[vpw_pkg::CLIP_W-1:12]};
         ovf_ff <= ({12'd0, uc[vpw_pkg::CLIP_W-1:12]} >= ud);
         nb_ff  <= {uc[11:0], 30'd0};
         d_ff   <= ud;
         q_ff   <= '0;
         neg_ff <= num[vpw_pkg::CLIP_W-1] ^ den[vpw_pkg::CLIP_W-1];
      end else if (run_ff && (cnt_ff != '0)) begin
         r_ff  <= ge ? t_sub[vpw_pkg::CLIP_W-1:0] : t[vpw_pkg::CLIP_W-1:0];
         q_ff  <= {q_ff[vpw_pkg::QUOT_W-2:0], ge};
         nb_ff <= nb_ff << 1;
      end
      if (run_ff && (cnt_ff == '0)) begin
         quot_ff <= neg_ff ? -q_mag : q_mag;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/core/vertex_project_to_window_unit.sv
// Projection: the accepted word goes through the issue of half products to the shared
// multiply-accumulate unit, its drain, three divides, the viewport scale and the result;
// the input stalls meanwhile, so the block takes no new word until it is idle again.
// A clip w of zero skips the divides and the viewport scale. A load word only writes the store.
// The result register lets the next word in while it waits. Reset is synchronous: the matrix
// store reads as zero until written, registers take their reset values, and the block is idle.
module vertex_project_to_window_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  vpw_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output vpw_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [vpw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vpw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MAC    = 8'b0000_0010,
      ST_DRAIN  = 8'b0000_0100,
      ST_DSTART = 8'b0000_1000,
      ST_DWAIT  = 8'b0001_0000,
      ST_VPX    = 8'b0010_0000,
      ST_VPY    = 8'b0100_0000,
      ST_FIN    = 8'b1000_0000
   } state_type;

   state_type                             state_ff;
   state_type                             state_in;

   logic signed [15:0]                    vp_left_ff;
   logic signed [15:0]                    vp_bottom_ff;
   logic [14:0]                           vp_width_ff;
   logic [14:0]                           vp_height_ff;
   logic                                  rotate_ff;

   logic [vpw_pkg::MATRIX_WORDS-1:0]      vld_ff;
   logic                                  rd_vld_ff;
   logic [vpw_pkg::WORD_W-1:0]            rd_data;
   logic [vpw_pkg::ADDR_W-1:0]            raddr;

   logic [5:0]                            k_ff;
   vpw_pkg::tag_type                      t1_ff;
   vpw_pkg::tag_type                      t2_ff;
   vpw_pkg::tag_type                      t3_ff;
   vpw_pkg::tag_type                      t1_in;

   logic signed [vpw_pkg::COORD_W-1:0]    pt_ff [3];
   logic signed [vpw_pkg::COORD_W-1:0]    eye_ff [4];
   logic signed [vpw_pkg::CLIP_W-1:0]     clip_ff [4];
   logic                                  front_ff;
   logic                                  wz_ff;

   vpw_pkg::mac_ctl_type                  mac_ctl;
   logic signed [vpw_pkg::COORD_W-1:0]    mac_a;
   logic [vpw_pkg::WORD_W-1:0]            mac_d;
   logic signed [vpw_pkg::ACC_W-1:0]      acc;
   logic                                  row_done;

   logic [1:0]                            di_ff;
   logic                                  div_start;
   logic                                  div_done;
   logic signed [vpw_pkg::QUOT_W-1:0]     quot;
   logic signed [vpw_pkg::QUOT_W-1:0]     unit_s;
   logic signed [vpw_pkg::QUOT_W-1:0]     unit_ff [3];

   logic signed [vpw_pkg::QUOT_W-1:0]     vp_a;
   logic signed [15:0]                    vp_b;
   logic signed [vpw_pkg::VPM_W-1:0]      vp_prod;
   logic signed [vpw_pkg::VPM_W-1:0]      mx_ff;
   logic signed [vpw_pkg::VPM_W-1:0]      my_ff;

   logic [vpw_pkg::WIN_W-1:0]             wx;
   logic [vpw_pkg::WIN_W-1:0]             wy;
   logic [vpw_pkg::WIN_W-1:0]             rx;
   logic                                  rsp_valid_ff;
   vpw_pkg::rsp_type                      rsp_data_ff;
   vpw_pkg::rsp_type                      rsp_data_in;
   logic                                  req_acc;
   logic                                  out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_left_ff   <= '0;
         vp_bottom_ff <= '0;
         vp_width_ff  <= 15'd640;
         vp_height_ff <= 15'd480;
         rotate_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            vpw_pkg::CSR_VP_LEFT:     vp_left_ff   <= csr_wdata;
            vpw_pkg::CSR_VP_BOTTOM:   vp_bottom_ff <= csr_wdata;
            vpw_pkg::CSR_VP_WIDTH:    vp_width_ff  <= csr_wdata[14:0];
            vpw_pkg::CSR_VP_HEIGHT:   vp_height_ff <= csr_wdata[14:0];
            vpw_pkg::CSR_ROTATE_VIEW: rotate_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Matrix store; a word never loaded reads as zero through its valid bit.
   assign raddr = {k_ff[5], k_ff[2:1], k_ff[4:3]};

   vpw_ram #(
      .WIDTH (vpw_pkg::WORD_W),
      .DEPTH (vpw_pkg::MATRIX_WORDS)
   ) u_store (
      .clock (clock),
      .we    (req_acc && (req_data.op == vpw_pkg::OP_LOAD)),
      .waddr (req_data.word_index),
      .wdata (req_data.word_value),
      .raddr (raddr),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (req_acc && (req_data.op == vpw_pkg::OP_LOAD)) begin
         vld_ff[req_data.word_index] <= 1'b1;
      end
      rd_vld_ff <= vld_ff[raddr];
   end

   // Step schedule: k counts half products; phase, row and term follow from its bits.
   always_comb begin
      t1_in.valid = (state_ff == ST_MAC);
      t1_in.phase = k_ff[5];
      t1_in.row   = k_ff[4:3];
      t1_in.term  = k_ff[2:1];
      t1_in.hi    = k_ff[0];
   end

   // Operand selection for the shared unit; the fourth eye term is the translation times 256.
   always_comb begin
      mac_d = rd_vld_ff ? rd_data : '0;
      if (!t1_ff.phase) begin
         case (t1_ff.term)
            2'd0:    mac_a = pt_ff[0];
            2'd1:    mac_a = pt_ff[1];
            2'd2:    mac_a = pt_ff[2];
            default: mac_a = 32'sd256;
         endcase
      end else begin
         mac_a = eye_ff[t1_ff.term];
      end
      mac_ctl.en    = t1_ff.valid;
      mac_ctl.hi    = t1_ff.hi;
      mac_ctl.first = (t1_ff.term == 2'd0) && !t1_ff.hi;
   end

   vpw_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .a     (mac_a),
      .d     (mac_d),
      .acc   (acc)
   );

   assign row_done = t3_ff.valid && t3_ff.hi && (t3_ff.term == 2'd3);

   // Divider for the three perspective divides.
   assign div_start = (state_ff == ST_DSTART) && (clip_ff[3] != '0);

   vpw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (clip_ff[di_ff]),
      .den   (clip_ff[3]),
      .done  (div_done),
      .quot  (quot)
   );

   // ndc*0.5 + 0.5 with a floor.
   always_comb begin
      unit_s = quot + (42'sd1 <<< 30);
   end

   // Viewport scale, one axis a cycle.
   always_comb begin
      if (state_ff == ST_VPX) begin
         vp_a = unit_ff[0];
         vp_b = {1'b0, vp_width_ff};
      end else begin
         vp_a = unit_ff[1];
         vp_b = {1'b0, vp_height_ff};
      end
      vp_prod = vp_a * vp_b;
   end

   // Window coordinates, rotation and saturation; zero window fields for a clip w of zero.
   always_comb begin
      wx = {{28{vp_left_ff[15]}}, vp_left_ff, 16'd0}
           + {{16{mx_ff[vpw_pkg::VPM_W-1]}}, mx_ff[vpw_pkg::VPM_W-1:14]};
      wy = {{28{vp_bottom_ff[15]}}, vp_bottom_ff, 16'd0}
           + {{16{my_ff[vpw_pkg::VPM_W-1]}}, my_ff[vpw_pkg::VPM_W-1:14]};
      rx = {29'd0, vp_height_ff, 16'd0} - wy;
      rsp_data_in.eye_x    = eye_ff[0];
      rsp_data_in.eye_y    = eye_ff[1];
      rsp_data_in.eye_z    = eye_ff[2];
      rsp_data_in.in_front = front_ff;
      rsp_data_in.w_zero   = wz_ff;
      if (wz_ff) begin
         rsp_data_in.win_x     = '0;
         rsp_data_in.win_y     = '0;
         rsp_data_in.win_depth = '0;
      end else begin
         if (rotate_ff) begin
            rsp_data_in.win_x = vpw_pkg::sat32(rx);
            rsp_data_in.win_y = vpw_pkg::sat32(wx);
         end else begin
            rsp_data_in.win_x = vpw_pkg::sat32(wx);
            rsp_data_in.win_y = vpw_pkg::sat32(wy);
         end
         rsp_data_in.win_depth = vpw_pkg::sat32(
            {{(vpw_pkg::WIN_W-vpw_pkg::QUOT_W){unit_ff[2][vpw_pkg::QUOT_W-1]}}, unit_ff[2]});
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_data.op == vpw_pkg::OP_PROJECT)) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (k_ff == 6'd63) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (row_done && t3_ff.phase && (t3_ff.row == 2'd3)) begin
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: begin
            state_in = (clip_ff[3] == '0) ? ST_FIN : ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               state_in = (di_ff == 2'd2) ? ST_VPX : ST_DSTART;
            end
         end
         ST_VPX: state_in = ST_VPY;
         ST_VPY: state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         di_ff        <= '0;
         t1_ff        <= '0;
         t2_ff        <= '0;
         t3_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         t1_ff    <= t1_in;
         t2_ff    <= t1_ff;
         t3_ff    <= t2_ff;
         if (state_ff == ST_MAC) begin
            k_ff <= k_ff + 6'd1;
         end else begin
            k_ff <= '0;
         end
         if (state_ff == ST_IDLE) begin
            di_ff <= '0;
         end else if ((state_ff == ST_DWAIT) && div_done) begin
            di_ff <= di_ff + 2'd1;
         end
         if ((state_ff == ST_FIN) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_acc) begin
         pt_ff[0] <= req_data.point_x;
         pt_ff[1] <= req_data.point_y;
         pt_ff[2] <= req_data.point_z;
      end
      // A finished row leaves the accumulator for the eye or clip registers.
      if (row_done) begin
         if (!t3_ff.phase) begin
            eye_ff[t3_ff.row] <= vpw_pkg::sat32(acc[vpw_pkg::ACC_W-1:24]);
            if (t3_ff.row == 2'd2) begin
               front_ff <= !acc[vpw_pkg::ACC_W-1] && (acc != '0);
            end
         end else begin
            clip_ff[t3_ff.row] <= vpw_pkg::sat64(acc[vpw_pkg::ACC_W-1:16]);
         end
      end
      if (state_ff == ST_DSTART) begin
         wz_ff <= (clip_ff[3] == '0);
      end
      if ((state_ff == ST_DWAIT) && div_done) begin
         unit_ff[di_ff] <= {unit_s[vpw_pkg::QUOT_W-1], unit_s[vpw_pkg::QUOT_W-1:1]};
      end
      if (state_ff == ST_VPX) begin
         mx_ff <= vp_prod;
      end
      if (state_ff == ST_VPY) begin
         my_ff <= vp_prod;
      end
      if ((state_ff == ST_FIN) && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A clip w of zero gives zero window fields.
   a_wzero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.w_zero) |->
      (rsp_data.win_x == '0) && (rsp_data.win_y == '0) && (rsp_data.win_depth == '0))
      else $error("w_zero result with non-zero window fields");

   // A load word never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.op == vpw_pkg::OP_LOAD)) |=> !$rose(rsp_valid))
      else $error("result word appeared after a matrix load");

   // The divider is never started with a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (clip_ff[3] != '0))
      else $error("divider started with clip w of zero");

   // The shared unit is only fed while the schedule runs or drains.
   a_mac_busy: assert property (@(posedge clock) disable iff (reset)
      t1_ff.valid |-> ((state_ff == ST_MAC) || (state_ff == ST_DRAIN)))
      else $error("multiply step outside the product schedule");

endmodule
